@@ sv/rvh_pkg.sv @@
// ============================================================================
// rvh_pkg
// Shared constants and types for the ray value histogram accumulator.
// ============================================================================
package rvh_pkg;

    localparam int BINS_DEFAULT = 64;
    localparam int VAL_W        = 17;
    localparam int FRAC_W       = 16;
    localparam int BIN_SEL_W    = 6;
    localparam int HIT_W        = 7;

    typedef logic [VAL_W-1:0]     q16_t;
    typedef logic [1:0]           opcode_t;
    typedef logic [BIN_SEL_W-1:0] bin_sel_t;
    typedef logic [HIT_W-1:0]     hit_cnt_t;

    localparam opcode_t OP_INTEGRATE = 2'd0;
    localparam opcode_t OP_CLEAR     = 2'd1;
    localparam opcode_t OP_READ      = 2'd2;
    localparam opcode_t OP_RESERVED  = 2'd3;

    localparam q16_t     ONE_Q16     = 17'h10000;
    localparam q16_t     NEAR_EQ_LSB = 17'd6;
    localparam hit_cnt_t HIT_MAX     = 7'd127;

endpackage

@@ sv/rvh_req_if.sv @@
// ============================================================================
// rvh_req_if
// Input channel carrying one segment or command beat.
// ============================================================================
interface rvh_req_if;
    import rvh_pkg::*;

    logic     valid;
    logic     ready;
    opcode_t  opcode;
    q16_t     value_start;
    q16_t     value_end;
    q16_t     depth_start;
    q16_t     depth_end;
    q16_t     start_attenuation;
    bin_sel_t read_bin;

    modport source (output valid, opcode, value_start, value_end, depth_start, depth_end,
                    start_attenuation, read_bin, input ready);
    modport sink (input valid, opcode, value_start, value_end, depth_start, depth_end,
                  start_attenuation, read_bin, output ready);
endinterface

@@ sv/rvh_rsp_if.sv @@
// ============================================================================
// rvh_rsp_if
// Output channel carrying one result beat.
// ============================================================================
interface rvh_rsp_if;
    import rvh_pkg::*;

    logic     valid;
    logic     ready;
    q16_t     attenuation_now;
    q16_t     bin_weight;
    q16_t     bin_depth;
    hit_cnt_t bins_hit;

    modport source (output valid, attenuation_now, bin_weight, bin_depth, bins_hit,
                    input ready);
    modport sink (input valid, attenuation_now, bin_weight, bin_depth, bins_hit,
                  output ready);
endinterface

@@ sv/rvh_ram.sv @@
// ============================================================================
// rvh_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module rvh_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/rvh_interp.sv @@
// ============================================================================
// rvh_interp
// Depth interpolation unit: two products, a rounding sum and a restoring
// divider that yields one quotient bit per cycle.
// ============================================================================
module rvh_interp #(
    parameter int LW = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rvh_pkg::q16_t ds,
    input  rvh_pkg::q16_t de,
    input  logic [LW-1:0] num,
    input  logic [LW-1:0] den,
    output logic          done,
    output rvh_pkg::q16_t depth
);
    import rvh_pkg::*;

    localparam int PW    = LW + VAL_W;
    localparam int CNT_W = $clog2(VAL_W + 1);

    typedef enum logic [3:0] {
        I_IDLE = 4'b0001,
        I_MUL  = 4'b0010,
        I_SUM  = 4'b0100,
        I_DIV  = 4'b1000
    } istate_t;

    istate_t          state_reg, state_next;
    q16_t             ds_reg, de_reg;
    logic [LW-1:0]    num_reg, den_reg;
    logic [PW-1:0]    p1_reg, p2_reg;
    logic [PW:0]      sum;
    logic [LW-1:0]    rem_reg;
    q16_t             q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [LW:0]      rem_sh;
    logic             q_bit;

    assign sum    = {1'b0, p1_reg} + {1'b0, p2_reg} + (PW+1)'(den_reg >> 1);
    assign rem_sh = {rem_reg, q_reg[VAL_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, den_reg});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            I_IDLE:  if (start) state_next = I_MUL;
            I_MUL:   state_next = I_SUM;
            I_SUM:   state_next = I_DIV;
            I_DIV:   if (cnt_reg == CNT_W'(VAL_W - 1)) state_next = I_IDLE;
            default: state_next = I_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= I_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == I_DIV) && (cnt_reg == CNT_W'(VAL_W - 1));
            if (state_reg == I_SUM)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == I_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == I_IDLE && start)
        begin
            ds_reg  <= ds;
            de_reg  <= de;
            num_reg <= num;
            den_reg <= den;
        end
        if (state_reg == I_MUL)
        begin
            p1_reg <= PW'(ds_reg) * PW'(den_reg - num_reg);
            p2_reg <= PW'(de_reg) * PW'(num_reg);
        end
        if (state_reg == I_SUM)
        begin
            rem_reg <= sum[PW-1:VAL_W];
            q_reg   <= sum[VAL_W-1:0];
        end
        else if (state_reg == I_DIV)
        begin
            rem_reg <= q_bit ? LW'(rem_sh - {1'b0, den_reg}) : rem_sh[LW-1:0];
            q_reg   <= {q_reg[VAL_W-2:0], q_bit};
        end
    end

    assign done  = done_reg;
    assign depth = q_reg;

endmodule

@@ sv/ray_value_histogram_accumulate.sv @@
// ============================================================================
// ray_value_histogram_accumulate
// Accumulates ray segments into a value histogram of weights and least depths.
// ============================================================================
// Weights and least depths live in two RAMs of BINS entries, updated by a
// read-modify-write for each bin whose centre a segment crosses. After reset,
// and for every clear beat, a clearing pass writes one entry per cycle; no
// beat is taken during the pass after reset. An integrate beat walks the bins
// from the start value's bin to the end value's bin, runs the bit-serial
// divider of the depth interpolation for each bin it hits (skipped when the
// segment's values are nearly equal), and then reads back the selected bin. A
// read beat reads the selected bin. A new beat is taken while the last result still waits.
module ray_value_histogram_accumulate #(
    parameter int BINS = rvh_pkg::BINS_DEFAULT
) (
    input logic     clk,
    input logic     rst_n,
    rvh_req_if.sink   req,
    rvh_rsp_if.source rsp
);
    import rvh_pkg::*;

    localparam int BW = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int LW = BW + 18;
    localparam int PV = VAL_W + BW + 1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CLEAR  = 7'b0000010,
        S_WALK   = 7'b0000100,
        S_INTERP = 7'b0001000,
        S_WB     = 7'b0010000,
        S_RD     = 7'b0100000,
        S_RESP   = 7'b1000000
    } state_t;

    state_t        state_reg, state_next;
    logic [BW-1:0] clr_reg, b_reg, be_reg, rb_addr_reg;
    logic          clr_resp_reg, rb_ok_reg, up_reg, near_reg;
    logic [LW-1:0] lo2_reg, hi2_reg;
    q16_t          ds_reg, de_reg, att_reg;
    hit_cnt_t      hits_reg;
    logic          rsp_valid_reg;
    q16_t          att_out_reg, wt_out_reg, dp_out_reg;
    hit_cnt_t      hits_out_reg;

    logic          accept;
    logic [PV-1:0] bs_raw, be_raw;
    logic [BW-1:0] bs_in, be_in;
    q16_t          vmin, vmax, diff;
    logic [LW-1:0] c2, num;
    logic          hit, last_bin, start_interp, interp_done;
    q16_t          interp_depth, inc, depth_new;
    logic [VAL_W:0] w_sum;
    q16_t          w_new;

    logic          ram_we, ram_re;
    logic [BW-1:0] ram_waddr, ram_raddr;
    q16_t          wt_wdata, dp_wdata, wt_rdata, dp_rdata;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign bs_raw = (PV'(req.value_start) * PV'(BINS)) >> FRAC_W;
    assign be_raw = (PV'(req.value_end) * PV'(BINS)) >> FRAC_W;
    assign bs_in  = (bs_raw > PV'(BINS - 1)) ? BW'(BINS - 1) : bs_raw[BW-1:0];
    assign be_in  = (be_raw > PV'(BINS - 1)) ? BW'(BINS - 1) : be_raw[BW-1:0];
    assign vmin   = (req.value_start < req.value_end) ? req.value_start : req.value_end;
    assign vmax   = (req.value_start < req.value_end) ? req.value_end : req.value_start;
    assign diff   = vmax - vmin;

    assign c2       = LW'({b_reg, 1'b1}) << FRAC_W;
    assign hit      = (lo2_reg <= c2) && (c2 <= hi2_reg);
    assign last_bin = (b_reg == be_reg);
    assign num      = up_reg ? (c2 - lo2_reg) : (hi2_reg - c2);
    assign start_interp = (state_reg == S_WALK) && hit && !near_reg;

    assign inc       = (att_reg < ONE_Q16) ? ((ONE_Q16 - att_reg) >> 4) : '0;
    assign w_sum     = {1'b0, wt_rdata} + {1'b0, inc};
    assign w_new     = (w_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : w_sum[VAL_W-1:0];
    assign depth_new = near_reg ? ds_reg : interp_depth;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = b_reg;
        wt_wdata  = w_new;
        dp_wdata  = (depth_new < dp_rdata) ? depth_new : dp_rdata;
        ram_re    = 1'b0;
        ram_raddr = b_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                wt_wdata  = '0;
                dp_wdata  = ONE_Q16;
            end
            S_WALK:   ram_re = hit;
            S_WB:     ram_we = 1'b1;
            S_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = rb_addr_reg;
            end
            default:  ram_we = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.opcode == OP_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                    else if (req.opcode == OP_INTEGRATE)
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_CLEAR:
            begin
                if (clr_reg == BW'(BINS - 1))
                begin
                    state_next = clr_resp_reg ? S_RD : S_IDLE;
                end
            end
            S_WALK:
            begin
                if (hit)
                begin
                    state_next = near_reg ? S_WB : S_INTERP;
                end
                else if (last_bin)
                begin
                    state_next = S_RD;
                end
            end
            S_INTERP: if (interp_done) state_next = S_WB;
            S_WB:     state_next = last_bin ? S_RD : S_WALK;
            S_RD:     state_next = S_RESP;
            S_RESP:   if (!rsp_valid_reg || rsp.ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            clr_resp_reg  <= 1'b0;
            att_reg       <= '0;
            hits_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= (clr_reg == BW'(BINS - 1)) ? '0 : clr_reg + 1'b1;
            end
            if (accept)
            begin
                clr_resp_reg <= 1'b1;
                hits_reg     <= '0;
                if (req.opcode == OP_CLEAR)
                begin
                    att_reg <= (req.start_attenuation > ONE_Q16) ? ONE_Q16
                                                                 : req.start_attenuation;
                end
            end
            if (state_reg == S_WB)
            begin
                att_reg <= att_reg + inc;
                if (hits_reg != HIT_MAX)
                begin
                    hits_reg <= hits_reg + 1'b1;
                end
            end
            if (state_reg == S_RESP && (!rsp_valid_reg || rsp.ready))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_reg       <= bs_in;
            be_reg      <= be_in;
            lo2_reg     <= LW'(vmin) * LW'(2 * BINS);
            hi2_reg     <= LW'(vmax) * LW'(2 * BINS);
            up_reg      <= (req.value_end > req.value_start);
            near_reg    <= (diff <= NEAR_EQ_LSB);
            ds_reg      <= req.depth_start;
            de_reg      <= req.depth_end;
            rb_addr_reg <= BW'(req.read_bin);
            rb_ok_reg   <= (32'(req.read_bin) < 32'(BINS));
        end
        else if ((state_reg == S_WALK && !hit && !last_bin)
                 || (state_reg == S_WB && !last_bin))
        begin
            b_reg <= (be_reg > b_reg) ? b_reg + 1'b1 : b_reg - 1'b1;
        end
        if (state_reg == S_RESP && (!rsp_valid_reg || rsp.ready))
        begin
            att_out_reg  <= att_reg;
            wt_out_reg   <= rb_ok_reg ? wt_rdata : '0;
            dp_out_reg   <= rb_ok_reg ? dp_rdata : ONE_Q16;
            hits_out_reg <= hits_reg;
        end
    end

    rvh_interp #(
        .LW (LW)
    ) u_interp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_interp),
        .ds    (ds_reg),
        .de    (de_reg),
        .num   (num),
        .den   (hi2_reg - lo2_reg),
        .done  (interp_done),
        .depth (interp_depth)
    );

    rvh_ram #(
        .WIDTH (VAL_W),
        .DEPTH (BINS),
        .AW    (BW)
    ) u_weight_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wt_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (wt_rdata)
    );

    rvh_ram #(
        .WIDTH (VAL_W),
        .DEPTH (BINS),
        .AW    (BW)
    ) u_depth_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (dp_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (dp_rdata)
    );

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.attenuation_now = att_out_reg;
    assign rsp.bin_weight      = wt_out_reg;
    assign rsp.bin_depth       = dp_out_reg;
    assign rsp.bins_hit        = hits_out_reg;

endmodule

@@ sv/rvh_checker.sv @@
// ============================================================================
// rvh_checker
// Port-level checks for the ray value histogram accumulator.
// ============================================================================
module rvh_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input rvh_pkg::q16_t     attenuation_now,
    input rvh_pkg::q16_t     bin_weight,
    input rvh_pkg::hit_cnt_t bins_hit
);
    import rvh_pkg::*;

    // A result beat that is not taken holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(attenuation_now)
                                    && $stable(bin_weight) && $stable(bins_hit))
        else $error("result beat changed while stalled");

    // The block works on one beat at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("input taken while busy");

    a_att_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> attenuation_now <= ONE_Q16)
        else $error("attenuation above one");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> bin_weight <= ONE_Q16)
        else $error("bin weight above one");

endmodule

bind ray_value_histogram_accumulate rvh_checker u_rvh_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .attenuation_now (rsp.attenuation_now),
    .bin_weight      (rsp.bin_weight),
    .bins_hit        (rsp.bins_hit)
);
